@@ hdl/uafr_pkg.sv @@
// Package for the acknowledge frame receiver: item kinds, outcome codes,
// frame constants and configuration register indexes.
// No dependencies.
package uafr_pkg;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_BYTE  = 2'd1,
        OP_TICK  = 2'd2,
        OP_NONE  = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        OUTCOME_ACK     = 2'd0,
        OUTCOME_NAK     = 2'd1,
        OUTCOME_TIMEOUT = 2'd2
    } outcome_t;

    typedef enum logic [1:0] {
        CFG_EXPECTED_CLASS  = 2'd0,
        CFG_EXPECTED_MSG_ID = 2'd1,
        CFG_TIMEOUT_LIMIT   = 2'd2
    } cfg_index_t;

    localparam logic [7:0]  SYNC_FIRST  = 8'hB5;
    localparam logic [7:0]  SYNC_SECOND = 8'h62;
    localparam logic [7:0]  ACK_CLASS   = 8'h05;
    localparam logic [7:0]  ACK_ID_OK   = 8'h01;
    localparam logic [7:0]  ACK_ID_NAK  = 8'h00;
    localparam logic [7:0]  ACK_LEN_LO  = 8'h02;
    localparam logic [7:0]  ACK_LEN_HI  = 8'h00;
    localparam int          FRAME_LEN   = 10;
    localparam int          POS_W       = 4;

    // Byte positions inside a frame
    localparam logic [POS_W-1:0] POS_SYNC1 = POS_W'(0);
    localparam logic [POS_W-1:0] POS_SYNC2 = POS_W'(1);
    localparam logic [POS_W-1:0] POS_CLASS = POS_W'(2);
    localparam logic [POS_W-1:0] POS_ID    = POS_W'(3);
    localparam logic [POS_W-1:0] POS_LENLO = POS_W'(4);
    localparam logic [POS_W-1:0] POS_LENHI = POS_W'(5);
    localparam logic [POS_W-1:0] POS_ACLS  = POS_W'(6);
    localparam logic [POS_W-1:0] POS_AID   = POS_W'(7);
    localparam logic [POS_W-1:0] POS_CKA   = POS_W'(8);
    localparam logic [POS_W-1:0] POS_CKB   = POS_W'(FRAME_LEN - 1);

    localparam logic [7:0]  RST_EXPECTED_CLASS  = 8'd6;
    localparam logic [7:0]  RST_EXPECTED_MSG_ID = 8'd1;
    localparam logic [15:0] RST_TIMEOUT_LIMIT   = 16'd2000;

endpackage

@@ hdl/ubx_ack_frame_receiver_top.sv @@
// Top level of the acknowledge frame receiver: stream input and output,
// configuration write port and all frame checking logic.
// Depends on uafr_pkg.
//
// Usage:
//   Input stream (s_axis_*): one transaction per item. tuser carries the
//   kind (start, received byte, time tick), tdata the received byte.
//   A start arms the receiver and clears the frame position and tick count.
//   Bytes are gathered into 10-byte acknowledge frames (sync B5 62, class,
//   id, length, acknowledged class and id, two Fletcher checksum bytes);
//   a matching frame ends the wait with ACK or NAK, any other is dropped.
//   Ticks count elapsed time; reaching timeout_limit ends the wait with a
//   timeout. Bytes and ticks while not armed are dropped silently.
//   Output stream (m_axis_*): one transaction per result, outcome in
//   tdata[1:0]. The result passes through one input register and one
//   result register before it shows on m_axis_tvalid.
//   Throughput is one item per cycle while the output is not stalled;
//   checksum and header checks advance one byte at a time in running
//   registers, so no frame-wide logic exists. When the output is stalled
//   the result register holds; the input register still takes one more
//   item if it is empty, then s_axis_tready drops until the result is taken.
//   Reset clears the armed flag, frame position, tick count and both
//   valid flags, and loads the configuration reset values.
module ubx_ack_frame_receiver_top (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [7:0]                 s_axis_tdata,  // [7:0] rx_byte
    input  logic [1:0]                 s_axis_tuser,  // [1:0] opcode
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [7:0]                 m_axis_tdata,  // [1:0] outcome, [7:2] zero
    input  logic                       cfg_wr_en,
    input  logic [1:0]                 cfg_addr,
    input  logic [15:0]                cfg_wdata
);
    import uafr_pkg::*;

    // Configuration
    logic [7:0]  exp_class_reg;
    logic [7:0]  exp_id_reg;
    logic [15:0] timeout_limit_reg;

    // Input register
    logic        in_valid_reg;
    opcode_t     in_op_reg;
    logic [7:0]  in_byte_reg;

    // Receiver state
    logic             waiting_reg,  waiting_next;
    logic [POS_W-1:0] pos_reg,      pos_next;
    logic [15:0]      ticks_reg,    ticks_next;
    logic             hdr_ok_reg,   hdr_ok_next;
    logic             nak_reg,      nak_next;
    logic [7:0]       ack_cls_reg,  ack_cls_next;
    logic [7:0]       ack_id_reg,   ack_id_next;
    logic [7:0]       sum_a_reg,    sum_a_next;
    logic [7:0]       sum_b_reg,    sum_b_next;

    // Result register
    logic        out_valid_reg;
    outcome_t    outcome_reg;

    logic        proc_en;
    logic        res_valid;
    outcome_t    res_outcome;
    logic [7:0]  add_a;
    logic [15:0] ticks_inc;

    // Process the held item when the result slot is free or being emptied
    assign proc_en       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || proc_en;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, outcome_reg};

    assign add_a     = sum_a_reg + in_byte_reg;
    assign ticks_inc = (ticks_reg == 16'hFFFF) ? ticks_reg : ticks_reg + 16'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_class_reg     <= RST_EXPECTED_CLASS;
            exp_id_reg        <= RST_EXPECTED_MSG_ID;
            timeout_limit_reg <= RST_TIMEOUT_LIMIT;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index_t'(cfg_addr))
                CFG_EXPECTED_CLASS:  exp_class_reg     <= cfg_wdata[7:0];
                CFG_EXPECTED_MSG_ID: exp_id_reg        <= cfg_wdata[7:0];
                CFG_TIMEOUT_LIMIT:   timeout_limit_reg <= cfg_wdata;
                default:             ;
            endcase
        end
    end

    // Next state of the receiver for the item in the input register
    always_comb
    begin
        waiting_next = waiting_reg;
        pos_next     = pos_reg;
        ticks_next   = ticks_reg;
        hdr_ok_next  = hdr_ok_reg;
        nak_next     = nak_reg;
        ack_cls_next = ack_cls_reg;
        ack_id_next  = ack_id_reg;
        sum_a_next   = sum_a_reg;
        sum_b_next   = sum_b_reg;
        res_valid    = 1'b0;
        res_outcome  = OUTCOME_ACK;

        case (in_op_reg)
            OP_START:
            begin
                waiting_next = 1'b1;
                pos_next     = POS_SYNC1;
                ticks_next   = 16'd0;
            end
            OP_BYTE:
            begin
                if (waiting_reg)
                begin
                    case (pos_reg)
                        POS_SYNC1:
                        begin
                            if (in_byte_reg == SYNC_FIRST)
                            begin
                                pos_next    = POS_SYNC2;
                                hdr_ok_next = 1'b1;
                                sum_a_next  = 8'd0;
                                sum_b_next  = 8'd0;
                            end
                        end
                        POS_SYNC2:
                        begin
                            // Drop back to hunting without re-testing this byte
                            pos_next = (in_byte_reg == SYNC_SECOND) ? POS_CLASS : POS_SYNC1;
                        end
                        POS_CKA:
                        begin
                            hdr_ok_next = hdr_ok_reg && (in_byte_reg == sum_a_reg);
                            pos_next    = POS_CKB;
                        end
                        POS_CKB:
                        begin
                            pos_next = POS_SYNC1;
                            if (hdr_ok_reg && in_byte_reg == sum_b_reg
                                && ack_cls_reg == exp_class_reg
                                && ack_id_reg == exp_id_reg)
                            begin
                                res_valid    = 1'b1;
                                res_outcome  = nak_reg ? OUTCOME_NAK : OUTCOME_ACK;
                                waiting_next = 1'b0;
                            end
                        end
                        default:
                        begin
                            // Payload bytes two to seven: run the checksum
                            sum_a_next = add_a;
                            sum_b_next = sum_b_reg + add_a;
                            pos_next   = pos_reg + POS_W'(1);
                            case (pos_reg)
                                POS_CLASS:
                                    hdr_ok_next = hdr_ok_reg && (in_byte_reg == ACK_CLASS);
                                POS_ID:
                                begin
                                    hdr_ok_next = hdr_ok_reg
                                        && (in_byte_reg == ACK_ID_OK
                                            || in_byte_reg == ACK_ID_NAK);
                                    nak_next = (in_byte_reg == ACK_ID_NAK);
                                end
                                POS_LENLO:
                                    hdr_ok_next = hdr_ok_reg && (in_byte_reg == ACK_LEN_LO);
                                POS_LENHI:
                                    hdr_ok_next = hdr_ok_reg && (in_byte_reg == ACK_LEN_HI);
                                POS_ACLS:
                                    ack_cls_next = in_byte_reg;
                                POS_AID:
                                    ack_id_next = in_byte_reg;
                                default:
                                    pos_next = POS_SYNC1;
                            endcase
                        end
                    endcase
                end
            end
            OP_TICK:
            begin
                if (waiting_reg)
                begin
                    ticks_next = ticks_inc;
                    if (ticks_inc >= timeout_limit_reg)
                    begin
                        res_valid    = 1'b1;
                        res_outcome  = OUTCOME_TIMEOUT;
                        waiting_next = 1'b0;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            waiting_reg   <= 1'b0;
            pos_reg       <= POS_SYNC1;
            ticks_reg     <= 16'd0;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;

            if (proc_en)
                out_valid_reg <= in_valid_reg && res_valid;

            if (in_valid_reg && proc_en)
            begin
                waiting_reg <= waiting_next;
                pos_reg     <= pos_next;
                ticks_reg   <= ticks_next;
            end
        end
    end

    // Payload registers: no reset
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_op_reg   <= opcode_t'(s_axis_tuser);
            in_byte_reg <= s_axis_tdata;
        end
        if (proc_en && in_valid_reg && res_valid)
            outcome_reg <= res_outcome;
        if (in_valid_reg && proc_en)
        begin
            hdr_ok_reg  <= hdr_ok_next;
            nak_reg     <= nak_next;
            ack_cls_reg <= ack_cls_next;
            ack_id_reg  <= ack_id_next;
            sum_a_reg   <= sum_a_next;
            sum_b_reg   <= sum_b_next;
        end
    end

endmodule
